// File: sv/crcmsb_pkg.sv
// Shared types, constants and the bytewise CRC function for the MSB-first CRC-32 checker.
package crcmsb_pkg;

  localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
  localparam int          CRC_WIDTH  = 32;
  localparam logic [2:0]  LOAD_COUNT = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // CRC of one byte placed in the top bits: eight polynomial steps.
  function automatic logic [CRC_WIDTH-1:0] byte_crc(input logic [7:0] b);
    logic [CRC_WIDTH-1:0] r;
    r = {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if (r[CRC_WIDTH-1]) begin
        r = {r[CRC_WIDTH-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[CRC_WIDTH-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: sv/crcmsb_in_reg.sv
// Input register stage: holds one accepted byte until the core takes it.
module crcmsb_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  crcmsb_pkg::item_t   in_item,
  output logic                item_valid,
  output crcmsb_pkg::item_t   item,
  input  logic                advance
);
  import crcmsb_pkg::*;

  item_t item_q;

  assign in_ready = !item_valid || advance;
  assign item     = item_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= in_item;
    end
  end

endmodule

// File: sv/crcmsb_core.sv
// CRC state update and result register.
module crcmsb_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  crcmsb_pkg::item_t   item,
  output logic                advance,
  output logic                res_valid,
  input  logic                res_ready,
  output logic [31:0]         res_crc,
  output logic                res_short
);
  import crcmsb_pkg::*;

  logic [CRC_WIDTH-1:0] shift_register;
  logic [CRC_WIDTH-1:0] shift_register_next;
  logic [2:0]           bytes_seen;
  logic [2:0]           bytes_seen_next;
  logic [CRC_WIDTH-1:0] shifted;

  // Stall only a last byte while an earlier result still waits.
  assign advance = item_valid && (!item.last_byte || !res_valid || res_ready);
  assign shifted = {shift_register[CRC_WIDTH-9:0], item.data_byte};

  always_comb begin
    if (bytes_seen < LOAD_COUNT) begin
      bytes_seen_next     = bytes_seen + 3'd1;
      shift_register_next = (bytes_seen_next == LOAD_COUNT) ? ~shifted : shifted;
    end else begin
      bytes_seen_next     = bytes_seen;
      shift_register_next = shifted ^ byte_crc(shift_register[CRC_WIDTH-1 -: 8]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_register <= '0;
      bytes_seen     <= '0;
    end else if (advance) begin
      if (item.last_byte) begin
        shift_register <= '0;
        bytes_seen     <= '0;
      end else begin
        shift_register <= shift_register_next;
        bytes_seen     <= bytes_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && item.last_byte) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_byte) begin
      if (bytes_seen_next < LOAD_COUNT) begin
        res_crc   <= '0;
        res_short <= 1'b1;
      end else begin
        res_crc   <= ~shift_register_next;
        res_short <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= LOAD_COUNT)
    else $error("byte count above load count");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && item.last_byte |=> bytes_seen == 3'd0 && shift_register == '0)
    else $error("state not cleared after last byte");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_short |-> res_crc == '0)
    else $error("short message result not zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !(advance && item.last_byte))
    else $error("pending result overwritten");

endmodule

// File: sv/crc32_msb_shift_in_checker.sv
// Top level of the MSB-first CRC-32 shift-in checker.
//
// Usage:
//   The slave channel takes a message one byte per transaction: s_tdata
//   carries the byte and s_tlast marks the final byte. The first four
//   bytes load the register MSB-first (then it is complemented); each
//   later byte shifts in while the byte leaving the top is folded back
//   through polynomial 0x04C11DB7. On the last byte one result
//   transaction leaves on the master channel: m_tdata is the complemented
//   register, m_tuser flags a message shorter than four bytes (then
//   m_tdata is 0). State clears after every last byte.
//   A last byte passes from the input register straight into the result
//   register, unless an earlier result still waits on the master side.
//   Throughput: one byte per cycle while no last byte waits on such a
//   result; the byte CRC is an eight-step XOR network between the input
//   register and the state register.
//   Reset: rst clears both stages and the CRC state; no result pending.
//   Stall: while m_tready is low a held result keeps the master side; non-
//   last bytes keep flowing, a last byte waits in the input register, and
//   s_tready drops only once that register is occupied and cannot drain.
module crc32_msb_shift_in_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] crc_value
  output logic        m_tuser    // [0] short_message
);
  import crcmsb_pkg::*;

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  advance;

  // Pack the slave fields into one item.
  assign in_item.data_byte = s_tdata;
  assign in_item.last_byte = s_tlast;

  // Hold the accepted byte until the core can take it.
  crcmsb_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance)
  );

  // Advance the CRC state and register the result on the last byte.
  crcmsb_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res_crc    (m_tdata),
    .res_short  (m_tuser)
  );

endmodule

// File: tb/tb_crc32_msb_shift_in_checker.sv
// Self-checking testbench for the MSB-first CRC-32 shift-in checker.
module tb_crc32_msb_shift_in_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import crcmsb_pkg::*;

  // Expected outcome of one message: the final CRC word and the short flag.
  typedef struct {
    bit [CRC_WIDTH-1:0] crc;
    bit                 short_msg;
  } crc_result_t;

  // Tracks the running CRC of the message in flight and holds the results
  // that are still due on the master side, oldest first.
  class crc_msg_tracker;
    localparam bit [31:0] GEN_POLY  = 32'h04C1_1DB7;
    localparam int        LOAD_BYTES = 4;

    bit [31:0]   crc_reg;
    int unsigned loaded;
    crc_result_t pending_crcs[$];
    int unsigned mismatches;

    function new();
      crc_reg     = '0;
      loaded      = 0;
      mismatches  = 0;
    endfunction

    // Divide one byte, sitting in the top bits, by the generator polynomial.
    function bit [31:0] fold_out_byte(bit [7:0] top_byte);
      bit [31:0] rem;
      rem = {top_byte, 24'h0};
      repeat (8) rem = {rem[30:0], 1'b0} ^ (rem[31] ? GEN_POLY : 32'h0);
      return rem;
    endfunction

    function int unsigned pending();
      return pending_crcs.size();
    endfunction

    // Print one line per mismatch and count it.
    task report(string msg);
      mismatches++;
      $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Advance the CRC state by one accepted byte; queue a result on the last one.
    function void take_byte(bit [7:0] data_byte, bit last_byte);
      crc_result_t res;
      if (loaded < LOAD_BYTES) begin
        crc_reg = {crc_reg[23:0], data_byte};
        loaded++;
        if (loaded == LOAD_BYTES) crc_reg = ~crc_reg;
      end else begin
        crc_reg = {crc_reg[23:0], data_byte} ^ fold_out_byte(crc_reg[31:24]);
      end
      if (last_byte) begin
        res.short_msg = (loaded < LOAD_BYTES);
        res.crc       = res.short_msg ? 32'h0 : ~crc_reg;
        pending_crcs.push_back(res);
        crc_reg = '0;
        loaded  = 0;
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    task check_result(logic [CRC_WIDTH-1:0] crc, logic short_msg);
      crc_result_t want;
      if (pending_crcs.size() == 0) begin
        report($sformatf("unexpected result crc=%h short=%b", crc, short_msg));
      end else begin
        want = pending_crcs.pop_front();
        if (crc !== want.crc)
          report($sformatf("crc_value %h, expected %h", crc, want.crc));
        if (short_msg !== want.short_msg)
          report($sformatf("short_message %b, expected %b", short_msg, want.short_msg));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
  logic        s_tlast = 1'b0;    // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] crc_value
  logic        m_tuser;           // [0] short_message

  crc_msg_tracker tracker = new();

  bit [7:0]    msg_q[$];          // bytes of the next message to send
  bit          calm_sender;       // no gaps on the slave side while set
  int unsigned bytes_sent;

  crc32_msb_shift_in_checker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Gap length: mostly none, often a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random message byte, with the all-zero and all-one patterns made likely.
  function automatic bit [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 8'h00;
    if (r < 10) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one byte, hold it until the slave side takes it, then note the
  // transaction. Called at a rising edge and returns at the accepting edge.
  task automatic send_byte(input bit [7:0] data_byte, input bit last_byte);
    int unsigned gap;
    gap = calm_sender ? 0 : pick_gap();
    if (gap != 0) begin
      // Drop valid and scramble the data lines while idle.
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data_byte;
    s_tlast  <= last_byte;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(data_byte, last_byte);
    bytes_sent++;
  endtask

  // Send the queued message, tlast on its final byte.
  task automatic send_message();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  // Master side: random back-pressure, short stalls mostly, a few long
  // ones, and calm stretches where, after any stall in progress, the result is taken at once.
  int unsigned stall_left = 0;
  int unsigned mode_left = 0;
  bit          calm_receiver = 1'b0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left     = $urandom_range(50, 400);
      calm_receiver = ($urandom_range(0, 3) == 0);
    end else begin
      mode_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (calm_receiver) begin
      m_tready <= 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          stall_left = $urandom_range(0, 2);
          m_tready <= 1'b0;
        end
        3: begin
          stall_left = $urandom_range(9, 39);
          m_tready <= 1'b0;
        end
        default: m_tready <= 1'b1;
      endcase
    end
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser);
  end

  initial begin
    int unsigned len;
    int unsigned r;

    calm_sender = 1'b0;
    bytes_sent  = 0;

    // Hold reset once at the start, then release it.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part: short messages of every length, exactly four bytes
    // (result equals the bytes as loaded), and longer ones with extremes.
    msg_q = '{8'h00};                                send_message();
    msg_q = '{8'hFF};                                send_message();
    msg_q = '{8'hFF, 8'h00};                         send_message();
    msg_q = '{8'h80, 8'h01, 8'h7F};                  send_message();
    msg_q = '{8'hDE, 8'hAD, 8'hBE, 8'hEF};           send_message();
    msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};           send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00};           send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};    send_message();
    msg_q = '{8'hFF, 8'h80, 8'h01, 8'hA5, 8'h5A};    send_message();

    // Random part: messages of random length and content, mostly long
    // enough to reach the shifting phase.
    while (bytes_sent < 1225) begin
      calm_sender = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) len = $urandom_range(1, 3);
      else if (r < 25) len = 4;
      else if (r < 85) len = $urandom_range(5, 16);
      else len = $urandom_range(17, 64);
      msg_q.delete();
      repeat (len) msg_q.push_back(pick_byte());
      send_message();
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every expected result, then let the pipeline settle.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: a correct run ends far earlier than this.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
sv/crcmsb_pkg.sv
sv/crcmsb_in_reg.sv
sv/crcmsb_core.sv
sv/crc32_msb_shift_in_checker.sv
tb/tb_crc32_msb_shift_in_checker.sv
